@@ hdl/free_block_bitmap_allocator_unit_macros.svh @@
// assertion macros for the free block bitmap allocator
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define FBBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FBBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBBA_ASSERT(lbl, clk, rstn, prop, msg)
`define FBBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/fbba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fbba_pkg;

  localparam logic [1:0] REQ_FIND = 2'd0;
  localparam logic [1:0] REQ_USED = 2'd1;
  localparam logic [1:0] REQ_FREE = 2'd2;

  localparam logic [1:0] STAT_FOUND   = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_MARKED  = 2'd2;

  localparam logic [7:0] MAP_BYTE_FULL = 8'hff;
  localparam logic [7:0] MAP_BYTE_TAIL = 8'hc0;
  localparam logic [7:0] MAP_BIT_ONE   = 8'h01;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] block_number;
    logic [3:0]  block_count;
  } item_t;

  typedef struct packed {
    logic [11:0] found_block;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // power-on contents of the map, blocks 0..15, 22 and 23 in use
  function automatic logic [7:0] map_init_byte(input logic [15:0] idx);
    logic [7:0] val;
    case (idx)
      16'd0, 16'd1: val = MAP_BYTE_FULL;
      16'd2:        val = MAP_BYTE_TAIL;
      default:      val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

@@ hdl/fbba_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fbba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hdl/free_block_bitmap_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "free_block_bitmap_allocator_unit_macros.svh"
// Free block bitmap allocator: one map bit per block, 1 = used, 0 = free.
// Request channel: item_i is taken at a rising edge with start high and busy
// low. req_type find scans the map upward from byte SEARCH_START_BYTE and
// reports the first block_count free blocks (at most MAX_REQUEST), ascending,
// last one flagged; too few free gives one no-space item, a zero count none.
// Mark used / mark free update one bit (none past the map end) and give one
// mark-done item. Other request codes give nothing.
// Result channel: each item on result_o for one cycle with result_valid_o;
// the receiver cannot stall, so no back-pressure exists.
// Steps: a mark reads the map byte, then writes it back with its bit changed
// and gives its result. A find reads the map memory one byte per cycle, but
// holds while it picks free blocks from the byte on hand, then replays its
// list from the found memory one item per cycle. The map memory has a single
// read port.
// Reset: busy stays high while a clearing pass writes the power-on map
// contents into the memory.
module free_block_bitmap_allocator_unit #(
  parameter int unsigned MAP_BLOCKS        = 4096,
  parameter int unsigned MAX_REQUEST       = 10,
  parameter int unsigned SEARCH_START_BYTE = 3
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire fbba_pkg::item_t item_i,
  output logic                 result_valid_o,
  output fbba_pkg::result_t    result_o
);
  import fbba_pkg::*;

  localparam int unsigned MapBytes = (MAP_BLOCKS + 7) / 8;
  localparam int unsigned ByteAw   = $clog2(MapBytes);
  localparam int unsigned BlkW     = ByteAw + 3;
  localparam int unsigned ExtW     = BlkW + 12;
  localparam int unsigned LastBits = MAP_BLOCKS - 8 * (MapBytes - 1);
  localparam logic [7:0]  LastMask = 8'((32'd1 << LastBits) - 32'd1);
  localparam int unsigned FoundAw  = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
  localparam int unsigned CntW     = $clog2(MAX_REQUEST + 1);
  localparam logic        StartOk  = (SEARCH_START_BYTE < MapBytes);
  localparam logic [ByteAw:0]   StartAddr = (ByteAw + 1)'(SEARCH_START_BYTE);
  localparam logic [ByteAw:0]   MapBytesW = (ByteAw + 1)'(MapBytes);
  localparam logic [ByteAw-1:0] LastByte  = ByteAw'(MapBytes - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_MARK  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [ByteAw-1:0] clr_q, clr_d;
  logic              rd_avail_q, rd_avail_d;
  logic [ByteAw-1:0] data_addr_q, data_addr_d;
  logic [ByteAw:0]   next_addr_q, next_addr_d;
  logic [7:0]        work_free_q, work_free_d;
  logic [ByteAw-1:0] work_byte_q, work_byte_d;
  logic [CntW-1:0]   have_q, have_d;
  logic [CntW-1:0]   need_q, need_d;
  logic [CntW-1:0]   emit_idx_q, emit_idx_d;
  logic              emit_pend_q, emit_pend_d;
  logic              emit_last_q, emit_last_d;
  logic              misc_valid_q, misc_valid_d;
  result_t           misc_res_q, misc_res_d;
  logic [ByteAw-1:0] mark_addr_q, mark_addr_d;
  logic [2:0]        mark_bit_q, mark_bit_d;
  logic              mark_set_q, mark_set_d;

  logic              map_we, map_re;
  logic [ByteAw-1:0] map_wa, map_ra;
  logic [7:0]        map_wd, map_rd;
  logic              fnd_we, fnd_re;
  logic [FoundAw-1:0] fnd_wa, fnd_ra;
  logic [11:0]       fnd_wd, fnd_rd;

  logic [2:0]        pick_bit;
  logic [ExtW-1:0]   found_ext;
  logic [ExtW-1:0]   mark_ext;
  logic              mark_in_range;
  logic [7:0]        byte_mask;
  logic [7:0]        mark_sel;
  logic [CntW-1:0]   req_cnt;

  fbba_ram #(
    .WIDTH (8),
    .DEPTH (MapBytes),
    .AW    (ByteAw)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_wa),
    .wdata_i (map_wd),
    .re_i    (map_re),
    .raddr_i (map_ra),
    .rdata_o (map_rd)
  );

  fbba_ram #(
    .WIDTH (12),
    .DEPTH (MAX_REQUEST),
    .AW    (FoundAw)
  ) u_found_ram (
    .clk_i   (clk_i),
    .we_i    (fnd_we),
    .waddr_i (fnd_wa),
    .wdata_i (fnd_wd),
    .re_i    (fnd_re),
    .raddr_i (fnd_ra),
    .rdata_o (fnd_rd)
  );

  // lowest free bit of the current byte
  always_comb begin
    pick_bit = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (work_free_q[i]) begin
        pick_bit = 3'(i);
      end
    end
  end

  assign found_ext     = ExtW'({work_byte_q, pick_bit});
  assign mark_ext      = ExtW'(item_i.block_number);
  assign mark_in_range = {20'd0, item_i.block_number} < 32'(MAP_BLOCKS);
  assign byte_mask     = (data_addr_q == LastByte) ? LastMask : 8'hff;
  assign mark_sel      = MAP_BIT_ONE << mark_bit_q;
  assign req_cnt       = ({28'd0, item_i.block_count} > 32'(MAX_REQUEST)) ?
                         CntW'(MAX_REQUEST) : CntW'(item_i.block_count);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    rd_avail_d   = rd_avail_q;
    data_addr_d  = data_addr_q;
    next_addr_d  = next_addr_q;
    work_free_d  = work_free_q;
    work_byte_d  = work_byte_q;
    have_d       = have_q;
    need_d       = need_q;
    emit_idx_d   = emit_idx_q;
    emit_pend_d  = 1'b0;
    emit_last_d  = emit_last_q;
    misc_valid_d = 1'b0;
    misc_res_d   = misc_res_q;
    mark_addr_d  = mark_addr_q;
    mark_bit_d   = mark_bit_q;
    mark_set_d   = mark_set_q;
    map_we       = 1'b0;
    map_wa       = '0;
    map_wd       = '0;
    map_re       = 1'b0;
    map_ra       = '0;
    fnd_we       = 1'b0;
    fnd_wa       = '0;
    fnd_wd       = '0;
    fnd_re       = 1'b0;
    fnd_ra       = '0;

    unique case (state_q)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_q;
        map_wd = map_init_byte(16'(clr_q));
        clr_d  = clr_q + 1'b1;
        if (clr_q == LastByte) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (item_i.req_type) inside
            REQ_FIND: begin
              if (item_i.block_count != 4'd0) begin
                need_d      = req_cnt;
                have_d      = '0;
                work_free_d = '0;
                if (StartOk) begin
                  map_re      = 1'b1;
                  map_ra      = StartAddr[ByteAw-1:0];
                  data_addr_d = StartAddr[ByteAw-1:0];
                  next_addr_d = StartAddr + 1'b1;
                  rd_avail_d  = 1'b1;
                  state_d     = S_SCAN;
                end else begin
                  misc_valid_d = 1'b1;
                  misc_res_d   = '{found_block: 12'd0, status: STAT_NOSPACE, last: 1'b1};
                end
              end
            end
            REQ_USED, REQ_FREE: begin
              mark_addr_d = mark_ext[BlkW-1:3];
              mark_bit_d  = item_i.block_number[2:0];
              mark_set_d  = (item_i.req_type == REQ_USED);
              if (mark_in_range) begin
                map_re  = 1'b1;
                map_ra  = mark_ext[BlkW-1:3];
                state_d = S_MARK;
              end else begin
                misc_valid_d = 1'b1;
                misc_res_d   = '{found_block: 12'd0, status: STAT_MARKED, last: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (work_free_q != 8'd0) begin
          fnd_we      = 1'b1;
          fnd_wa      = have_q[FoundAw-1:0];
          fnd_wd      = found_ext[11:0];
          work_free_d = work_free_q & (work_free_q - 8'd1);
          have_d      = have_q + 1'b1;
          if (CntW'(have_q + 1'b1) == need_q) begin
            emit_idx_d = '0;
            state_d    = S_EMIT;
          end
        end else if (rd_avail_q) begin
          work_free_d = ~map_rd & byte_mask;
          work_byte_d = data_addr_q;
          if (next_addr_q < MapBytesW) begin
            map_re      = 1'b1;
            map_ra      = next_addr_q[ByteAw-1:0];
            data_addr_d = next_addr_q[ByteAw-1:0];
            next_addr_d = next_addr_q + 1'b1;
          end else begin
            rd_avail_d = 1'b0;
          end
        end else begin
          misc_valid_d = 1'b1;
          misc_res_d   = '{found_block: 12'd0, status: STAT_NOSPACE, last: 1'b1};
          state_d      = S_IDLE;
        end
      end
      S_EMIT: begin
        fnd_re      = 1'b1;
        fnd_ra      = emit_idx_q[FoundAw-1:0];
        emit_pend_d = 1'b1;
        emit_last_d = (emit_idx_q == need_q - 1'b1);
        if (emit_idx_q == need_q - 1'b1) begin
          state_d = S_IDLE;
        end else begin
          emit_idx_d = emit_idx_q + 1'b1;
        end
      end
      S_MARK: begin
        map_we       = 1'b1;
        map_wa       = mark_addr_q;
        map_wd       = mark_set_q ? (map_rd | mark_sel) : (map_rd & ~mark_sel);
        misc_valid_d = 1'b1;
        misc_res_d   = '{found_block: 12'd0, status: STAT_MARKED, last: 1'b1};
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      rd_avail_q   <= 1'b0;
      next_addr_q  <= '0;
      work_free_q  <= '0;
      have_q       <= '0;
      need_q       <= '0;
      emit_idx_q   <= '0;
      emit_pend_q  <= 1'b0;
      emit_last_q  <= 1'b0;
      misc_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      rd_avail_q   <= rd_avail_d;
      next_addr_q  <= next_addr_d;
      work_free_q  <= work_free_d;
      have_q       <= have_d;
      need_q       <= need_d;
      emit_idx_q   <= emit_idx_d;
      emit_pend_q  <= emit_pend_d;
      emit_last_q  <= emit_last_d;
      misc_valid_q <= misc_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_addr_q <= data_addr_d;
    work_byte_q <= work_byte_d;
    misc_res_q  <= misc_res_d;
    mark_addr_q <= mark_addr_d;
    mark_bit_q  <= mark_bit_d;
    mark_set_q  <= mark_set_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = emit_pend_q | misc_valid_q;
  assign result_o       = emit_pend_q ?
                          '{found_block: fnd_rd, status: STAT_FOUND, last: emit_last_q} :
                          misc_res_q;

  `FBBA_ASSERT(a_quiet_clear, clk_i, rst_ni, (state_q == S_CLEAR) |-> !result_valid_o, "item during clearing pass")
  `FBBA_ASSERT(a_have_below_need, clk_i, rst_ni, (state_q == S_SCAN) |-> (have_q < need_q), "found count overran request")
  `FBBA_ASSERT(a_one_source, clk_i, rst_ni, !(emit_pend_q && misc_valid_q), "two result sources at once")
  `FBBA_ASSERT(a_map_write_owner, clk_i, rst_ni, map_we |-> (state_q == S_CLEAR || state_q == S_MARK), "stray map write")
  `FBBA_ASSERT_ALWAYS(a_reset_silent, clk_i, !rst_ni |=> !result_valid_o, "item strobe in reset")

endmodule
`default_nettype wire

@@ verif/tb_free_block_bitmap_allocator_unit.sv @@
`timescale 1ns / 1ps
module tb_free_block_bitmap_allocator_unit;
  import fbba_pkg::*;

  localparam int unsigned MAP_BLOCKS        = 4096;
  localparam int unsigned MAX_REQUEST       = 10;
  localparam int unsigned SEARCH_START_BYTE = 3;
  localparam int unsigned FIRST_SCAN_BLOCK  = SEARCH_START_BYTE * 8;
  localparam logic [1:0]  REQ_NONE          = 2'd3;
  localparam int unsigned DRAIN_CYCLES      = 600;

  typedef struct {
    item_t item;
    bit    hold;
  } alloc_req_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   req_item = '0;
  logic    result_valid_o;
  result_t result_o;

  alloc_req_t           req_queue[$];
  result_t              alloc_results_q[$];
  logic [MAP_BLOCKS-1:0] shadow_used_map;
  int unsigned          gen_free[$];

  int fail_count = 0;
  int n_accepted = 0;
  int n_finds = 0;
  int n_marks = 0;
  int n_found_res = 0;
  int n_nospace_res = 0;
  int n_mark_res = 0;
  int idle_left = 0;
  bit quiet;
  result_t want_res;

  free_block_bitmap_allocator_unit #(
    .MAP_BLOCKS       (MAP_BLOCKS),
    .MAX_REQUEST      (MAX_REQUEST),
    .SEARCH_START_BYTE(SEARCH_START_BYTE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (req_item),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic apply_request(input item_t it);
    int unsigned want;
    logic [11:0] picks[$];
    result_t r;
    case (it.req_type)
      REQ_FIND: begin
        want = it.block_count;
        if (want > MAX_REQUEST) want = MAX_REQUEST;
        if (want != 0) begin
          for (int b = FIRST_SCAN_BLOCK; b < MAP_BLOCKS && picks.size() < want; b++) begin
            if (!shadow_used_map[b]) picks.push_back(12'(b));
          end
          if (picks.size() < want) begin
            r.found_block = '0;
            r.status = STAT_NOSPACE;
            r.last = 1'b1;
            alloc_results_q.push_back(r);
          end else begin
            for (int k = 0; k < want; k++) begin
              r.found_block = picks[k];
              r.status = STAT_FOUND;
              r.last = (k == want - 1);
              alloc_results_q.push_back(r);
            end
          end
        end
      end
      REQ_USED, REQ_FREE: begin
        shadow_used_map[it.block_number] = (it.req_type == REQ_USED);
        r.found_block = '0;
        r.status = STAT_MARKED;
        r.last = 1'b1;
        alloc_results_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic add_req(input logic [1:0] kind, input int unsigned blk,
                         input int unsigned cnt, input bit hold);
    alloc_req_t e;
    e.item.req_type = kind;
    e.item.block_number = 12'(blk);
    e.item.block_count = 4'(cnt);
    e.hold = hold;
    req_queue.push_back(e);
    if (kind == REQ_FIND) n_finds++;
    else if (kind != REQ_NONE) n_marks++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_item <= '0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        apply_request(req_item);
        n_accepted++;
      end
      quiet = (n_accepted >= 120 && n_accepted < 220);
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 4) begin
          idle_left <= $urandom_range(0, 2);
          start <= 1'b0;
        end else if (req_queue.size() > 0 &&
                     !(req_queue[0].hold && alloc_results_q.size() != 0)) begin
          start <= 1'b1;
          req_item <= req_queue[0].item;
          void'(req_queue.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
    end else if (result_valid_o) begin
      if (alloc_results_q.size() == 0) begin
        $error("unexpected result: found_block %0d status %0d last %0d",
               result_o.found_block, result_o.status, result_o.last);
        fail_count++;
      end else begin
        want_res = alloc_results_q.pop_front();
        if (result_o.found_block !== want_res.found_block) begin
          $error("found_block mismatch: expected %0d, actual %0d",
                 want_res.found_block, result_o.found_block);
          fail_count++;
        end
        if (result_o.status !== want_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", want_res.status, result_o.status);
          fail_count++;
        end
        if (result_o.last !== want_res.last) begin
          $error("last mismatch: expected %0d, actual %0d", want_res.last, result_o.last);
          fail_count++;
        end
        case (want_res.status)
          STAT_FOUND:   n_found_res++;
          STAT_NOSPACE: n_nospace_res++;
          default:      n_mark_res++;
        endcase
      end
    end
  end

  initial begin
    int unsigned r, blk, cnt, idx;
    shadow_used_map = '0;
    for (int b = 0; b < 16; b++) shadow_used_map[b] = 1'b1;
    shadow_used_map[22] = 1'b1;
    shadow_used_map[23] = 1'b1;

    // fresh map
    add_req(REQ_FIND, 0, 1, 0);
    add_req(REQ_FIND, 12'hfff, 10, 0);
    add_req(REQ_FIND, 0, 15, 0);
    add_req(REQ_FIND, 12'h123, 0, 0);
    add_req(REQ_NONE, 12'hfff, 15, 0);
    add_req(REQ_USED, 24, 0, 1);
    add_req(REQ_FIND, 0, 1, 0);
    add_req(REQ_USED, 0, 0, 0);
    add_req(REQ_FREE, 0, 15, 0);
    add_req(REQ_USED, 4095, 0, 0);
    add_req(REQ_FREE, 4095, 0, 0);
    add_req(REQ_FREE, 12'hfff, 0, 0);
    add_req(REQ_USED, 16, 0, 0);
    add_req(REQ_FIND, 0, 2, 0);
    add_req(REQ_FREE, 24, 0, 0);
    add_req(REQ_FIND, 0, 10, 0);
    add_req(REQ_FREE, 12'h555, 5, 0);
    add_req(REQ_USED, 12'haaa, 10, 0);
    add_req(REQ_NONE, 0, 0, 0);

    add_req(REQ_FIND, 0, 1, 1);
    add_req(REQ_FIND, 0, 2, 0);
    add_req(REQ_FIND, 0, 15, 0);
    add_req(REQ_USED, 4095, 0, 0);
    add_req(REQ_FIND, 0, 1, 0);

    // random mix
    for (int i = 0; i < 325; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if ($urandom_range(0, 9) == 0 && gen_free.size() > 0)
          cnt = (gen_free.size() > MAX_REQUEST) ? MAX_REQUEST : gen_free.size();
        else if ($urandom_range(0, 4) == 0)
          cnt = $urandom_range(0, 15);
        else
          cnt = $urandom_range(1, MAX_REQUEST);
        add_req(REQ_FIND, $urandom_range(0, 4095), cnt, $urandom_range(0, 49) == 0);
      end else if (r < 65) begin
        if ($urandom_range(0, 4) == 0) blk = $urandom_range(0, 4095);
        else blk = $urandom_range(FIRST_SCAN_BLOCK, MAP_BLOCKS - 1);
        if (blk >= FIRST_SCAN_BLOCK) gen_free.push_back(blk);
        add_req(REQ_FREE, blk, $urandom_range(0, 15), 0);
      end else if (r < 92) begin
        if (gen_free.size() > 0 && $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, gen_free.size() - 1);
          blk = gen_free[idx];
          gen_free.delete(idx);
        end else begin
          blk = $urandom_range(0, 4095);
        end
        add_req(REQ_USED, blk, $urandom_range(0, 15), 0);
      end else begin
        add_req(REQ_NONE, $urandom_range(0, 4095), $urandom_range(0, 15), 0);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || start) @(posedge clk_i);
    while (alloc_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests sent: %0d finds, %0d marks, rest ignored codes",
             n_accepted, n_finds, n_marks);
    $display("results seen: %0d blocks found, %0d no-space, %0d mark done",
             n_found_res, n_nospace_res, n_mark_res);
    if (fail_count == 0 && alloc_results_q.size() == 0) begin
      $display("tb_free_block_bitmap_allocator_unit: PASS");
    end else begin
      $display("tb_free_block_bitmap_allocator_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_free_block_bitmap_allocator_unit: FAIL");
    $finish;
  end

endmodule
